/* rtl/core/i2c_master_byte_engine_macros.svh */
// assertion macros shared by the checker of the i2c master byte engine
// no dependencies; taken in by `include
`ifndef I2C_MASTER_BYTE_ENGINE_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define IMBE_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define IMBE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/imbe_pkg.sv */
// types and constants of the i2c master byte engine
// no dependencies; used by the interfaces and every module of the block
package imbe_pkg;

    localparam int CMD_W     = 3;
    localparam int BYTE_W    = 8;
    localparam int UNIT_W    = 16;
    localparam int TMO_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int BIT_CNT_W = 4;

    localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_UNIT_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 2'd1;

    localparam logic [UNIT_W-1:0] UNIT_RESET    = 16'd100;
    localparam logic [TMO_W-1:0]  TIMEOUT_RESET = 8'd50;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BYTE_W-1:0] tx_byte;
        logic              send_ack;
        logic              sda_in;
    } t_item;

    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              sda_drive;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              ack_error;
    } t_result;

endpackage

/* rtl/core/imbe_ifs.sv */
// channel interfaces of the i2c master byte engine: tick requests, results, register writes
// depends on imbe_pkg
interface imbe_item_if;
    import imbe_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] tx_byte;
    logic              send_ack;
    logic              sda_in;
    modport source (output valid, command, tx_byte, send_ack, sda_in, input ready);
    modport sink   (input valid, command, tx_byte, send_ack, sda_in, output ready);
endinterface

interface imbe_result_if;
    import imbe_pkg::*;
    logic              valid;
    logic              ready;
    logic              scl_level;
    logic              sda_level;
    logic              sda_drive;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_error;
    modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                    rx_byte, ack_error, input ready);
    modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                    rx_byte, ack_error, output ready);
endinterface

interface imbe_cfg_if;
    import imbe_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_DAT_W-1:0] wdata;
    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

/* rtl/core/imbe_cfg_regs.sv */
// configuration registers of the i2c master byte engine and the derived unit length
// depends on imbe_pkg and imbe_cfg_if
module imbe_cfg_regs #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    imbe_cfg_if.sink                    i_cfg,
    output logic [TIMER_WIDTH-1:0]      o_last_count,
    output logic [imbe_pkg::TMO_W-1:0]  o_ack_timeout
);
    import imbe_pkg::*;

    logic [UNIT_W-1:0] r_unit_ticks;
    logic [TMO_W-1:0]  r_ack_timeout;
    logic [UNIT_W-1:0] w_unit_last;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_ticks  <= UNIT_RESET;
            r_ack_timeout <= TIMEOUT_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                REG_UNIT_TICKS:  r_unit_ticks  <= i_cfg.wdata[UNIT_W-1:0];
                REG_ACK_TIMEOUT: r_ack_timeout <= i_cfg.wdata[TMO_W-1:0];
                default: ;
            endcase
        end
    end

    // zero ticks behaves as one tick
    assign w_unit_last = (r_unit_ticks == '0) ? '0 : (r_unit_ticks - 1'b1);

    generate
        if (TIMER_WIDTH > UNIT_W) begin : g_wide
            assign o_last_count = {{(TIMER_WIDTH-UNIT_W){1'b0}}, w_unit_last};
        end else if (TIMER_WIDTH == UNIT_W) begin : g_same
            assign o_last_count = w_unit_last;
        end else begin : g_sat
            // saturate to the longest unit the timer can count
            assign o_last_count = (|w_unit_last[UNIT_W-1:TIMER_WIDTH]) ? '1
                                : w_unit_last[TIMER_WIDTH-1:0];
        end
    endgenerate

    assign o_ack_timeout = r_ack_timeout;

endmodule

/* rtl/core/imbe_step.sv */
// input register, bus phase sequencer and line registers of the i2c master byte engine
// depends on imbe_pkg
module imbe_step #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  imbe_pkg::t_item             i_item,
    output logic                        o_in_ready,
    input  logic [TIMER_WIDTH-1:0]      i_last_count,
    input  logic [imbe_pkg::TMO_W-1:0]  i_ack_timeout,
    input  logic                        i_room,
    output logic                        o_push,
    output imbe_pkg::t_result           o_result
);
    import imbe_pkg::*;

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_START_HI = 4'd1;
    localparam logic [3:0] PH_START_LO = 4'd2;
    localparam logic [3:0] PH_STOP_LO  = 4'd3;
    localparam logic [3:0] PH_STOP_HI  = 4'd4;
    localparam logic [3:0] PH_W_SETUP  = 4'd5;
    localparam logic [3:0] PH_W_HIGH   = 4'd6;
    localparam logic [3:0] PH_W_LOW    = 4'd7;
    localparam logic [3:0] PH_A_REL    = 4'd8;
    localparam logic [3:0] PH_A_HIGH   = 4'd9;
    localparam logic [3:0] PH_R_LOW    = 4'd10;
    localparam logic [3:0] PH_R_HIGH   = 4'd11;
    localparam logic [3:0] PH_K_LOW    = 4'd12;
    localparam logic [3:0] PH_K_HIGH   = 4'd13;

    logic                   r_in_vld;
    t_item                  r_in;
    logic [3:0]             r_phase,  n_phase;
    logic [BIT_CNT_W-1:0]   r_bit,    n_bit;
    logic [TIMER_WIDTH-1:0] r_timer,  n_timer;
    logic [BYTE_W-1:0]      r_shift,  n_shift;
    logic [TMO_W-1:0]       r_retry,  n_retry;
    logic                   r_ack,    n_ack;
    logic                   r_scl,    n_scl;
    logic                   r_sda,    n_sda;
    logic                   r_drv,    n_drv;
    logic                   r_err,    n_err;
    logic [BYTE_W-1:0]      r_rcv,    n_rcv;
    logic                   n_done;
    logic                   w_adv;
    logic [BIT_CNT_W-1:0]   w_bit_inc;
    logic [BYTE_W-1:0]      w_shift_up;

    assign w_adv      = r_in_vld && i_room;
    assign o_in_ready = !r_in_vld || i_room;
    assign o_push     = w_adv;
    assign w_bit_inc  = r_bit + 1'b1;
    assign w_shift_up = {r_shift[BYTE_W-2:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_item;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_bit   = r_bit;
        n_timer = r_timer;
        n_shift = r_shift;
        n_retry = r_retry;
        n_ack   = r_ack;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_drv   = r_drv;
        n_err   = r_err;
        n_rcv   = r_rcv;
        n_done  = 1'b0;
        if (r_phase == PH_IDLE) begin
            n_timer = '0;
            unique case (r_in.command)
                CMD_START: begin
                    {n_scl, n_sda, n_drv} = 3'b111;
                    n_bit   = 4'd1;
                    n_phase = PH_START_HI;
                end
                CMD_STOP: begin
                    {n_scl, n_sda, n_drv} = 3'b001;
                    n_bit   = 4'd1;
                    n_phase = PH_STOP_LO;
                end
                CMD_WRITE: begin
                    n_shift = r_in.tx_byte;
                    n_bit   = '0;
                    n_retry = '0;
                    n_scl   = 1'b0;
                    n_sda   = r_in.tx_byte[BYTE_W-1];
                    n_drv   = 1'b1;
                    n_phase = PH_W_SETUP;
                end
                CMD_READ: begin
                    n_shift = '0;
                    n_bit   = '0;
                    n_ack   = r_in.send_ack;
                    n_scl   = 1'b0;
                    n_drv   = 1'b0;
                    n_phase = PH_R_LOW;
                end
                default: ;
            endcase
        end else if (r_timer < i_last_count) begin
            n_timer = r_timer + 1'b1;
        end else begin
            n_timer = '0;
            unique case (r_phase)
                PH_START_HI: begin
                    if (r_bit != '0) begin
                        n_bit = r_bit - 1'b1;
                    end else begin
                        {n_scl, n_sda, n_drv} = 3'b101;
                        n_bit   = 4'd1;
                        n_phase = PH_START_LO;
                    end
                end
                PH_START_LO: begin
                    if (r_bit != '0) begin
                        n_bit = r_bit - 1'b1;
                    end else begin
                        {n_scl, n_sda, n_drv} = 3'b001;
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end
                end
                PH_STOP_LO: begin
                    if (r_bit != '0) begin
                        n_bit = r_bit - 1'b1;
                    end else begin
                        {n_scl, n_sda, n_drv} = 3'b111;
                        n_bit   = 4'd1;
                        n_phase = PH_STOP_HI;
                    end
                end
                PH_STOP_HI: begin
                    if (r_bit != '0) begin
                        n_bit = r_bit - 1'b1;
                    end else begin
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end
                end
                PH_W_SETUP: begin
                    n_scl   = 1'b1;
                    n_phase = PH_W_HIGH;
                end
                PH_W_HIGH: begin
                    n_scl   = 1'b0;
                    n_phase = PH_W_LOW;
                end
                PH_W_LOW: begin
                    n_bit   = w_bit_inc;
                    n_shift = w_shift_up;
                    if (w_bit_inc[BIT_CNT_W-1]) begin
                        // all eight bits out, release sda for the ack slot
                        {n_scl, n_sda, n_drv} = 3'b010;
                        n_phase = PH_A_REL;
                    end else begin
                        n_sda   = w_shift_up[BYTE_W-1];
                        n_phase = PH_W_SETUP;
                    end
                end
                PH_A_REL: begin
                    n_scl   = 1'b1;
                    n_phase = PH_A_HIGH;
                end
                PH_A_HIGH: begin
                    if (!r_in.sda_in) begin
                        n_scl   = 1'b0;
                        n_err   = 1'b0;
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end else if (r_retry >= i_ack_timeout) begin
                        // no ack in time: flag it and run a stop
                        n_err   = 1'b1;
                        {n_scl, n_sda, n_drv} = 3'b001;
                        n_bit   = 4'd1;
                        n_phase = PH_STOP_LO;
                    end else begin
                        n_retry = r_retry + 1'b1;
                    end
                end
                PH_R_LOW: begin
                    n_scl   = 1'b1;
                    n_shift = {r_shift[BYTE_W-2:0], r_in.sda_in};
                    n_phase = PH_R_HIGH;
                end
                PH_R_HIGH: begin
                    n_bit = w_bit_inc;
                    if (w_bit_inc[BIT_CNT_W-1]) begin
                        n_rcv   = r_shift;
                        n_scl   = 1'b0;
                        n_sda   = !r_ack;
                        n_drv   = 1'b1;
                        n_phase = PH_K_LOW;
                    end else begin
                        n_scl   = 1'b0;
                        n_phase = PH_R_LOW;
                    end
                end
                PH_K_LOW: begin
                    n_scl   = 1'b1;
                    n_phase = PH_K_HIGH;
                end
                PH_K_HIGH: begin
                    n_scl   = 1'b0;
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bit   <= '0;
            r_timer <= '0;
            r_shift <= '0;
            r_retry <= '0;
            r_ack   <= 1'b0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_drv   <= 1'b1;
            r_err   <= 1'b0;
            r_rcv   <= '0;
        end else if (w_adv) begin
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_timer <= n_timer;
            r_shift <= n_shift;
            r_retry <= n_retry;
            r_ack   <= n_ack;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_drv   <= n_drv;
            r_err   <= n_err;
            r_rcv   <= n_rcv;
        end
    end

    always_comb begin
        o_result.scl_level = n_scl;
        o_result.sda_level = n_sda;
        o_result.sda_drive = n_drv;
        o_result.busy_res  = (n_phase != PH_IDLE);
        o_result.done_res  = n_done;
        o_result.rx_byte   = n_rcv;
        o_result.ack_error = n_err;
    end

endmodule

/* rtl/core/imbe_out_buf.sv */
// two-entry result register with skid slot for the i2c master byte engine
// depends on imbe_pkg and imbe_result_if
module imbe_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  imbe_pkg::t_result i_data,
    output logic              o_room,
    imbe_result_if.source     o_result
);
    import imbe_pkg::*;

    logic    r_main_vld, n_main_vld;
    logic    r_skid_vld, n_skid_vld;
    t_result r_main,     n_main;
    t_result r_skid,     n_skid;
    logic    w_pop;

    assign w_pop  = r_main_vld && o_result.ready;
    assign o_room = !r_skid_vld;

    always_comb begin
        n_main_vld = r_main_vld;
        n_main     = r_main;
        n_skid_vld = r_skid_vld;
        n_skid     = r_skid;
        if (w_pop) begin
            if (r_skid_vld) begin
                n_main     = r_skid;
                n_skid_vld = 1'b0;
            end else begin
                n_main_vld = 1'b0;
            end
        end
        if (i_push) begin
            if (!n_main_vld) begin
                n_main_vld = 1'b1;
                n_main     = i_data;
            end else begin
                n_skid_vld = 1'b1;
                n_skid     = i_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_main_vld <= n_main_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_result.valid     = r_main_vld;
    assign o_result.scl_level = r_main.scl_level;
    assign o_result.sda_level = r_main.sda_level;
    assign o_result.sda_drive = r_main.sda_drive;
    assign o_result.busy_res  = r_main.busy_res;
    assign o_result.done_res  = r_main.done_res;
    assign o_result.rx_byte   = r_main.rx_byte;
    assign o_result.ack_error = r_main.ack_error;

endmodule

/* rtl/core/i2c_master_byte_engine.sv */
// channel    | dir | handshake     | payload
// i_item     | in  | valid / ready | command, tx_byte, send_ack, sda_in
// o_result   | out | valid / ready | scl_level, sda_level, sda_drive, busy_res, done_res,
//            |     |               | rx_byte, ack_error
// i_cfg      | in  | valid / ready | reg_index, wdata (unit_ticks, ack_timeout)
//
// one tick request can be taken every cycle while the result side has room; the request
// is held in the input register, then its result in the result register, before it can be taken
// each request makes one pass through the phase sequencer
// synchronous active-low reset brings the lines to scl high, sda high and driven, idle
// a stalled result sink fills the skid slot; i_item.ready drops once the input register
// also holds a request; i_cfg is always ready
// top level, depends on imbe_pkg, imbe_ifs, imbe_cfg_regs, imbe_step, imbe_out_buf
module i2c_master_byte_engine #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    imbe_item_if.sink     i_item,
    imbe_result_if.source o_result,
    imbe_cfg_if.sink      i_cfg
);
    import imbe_pkg::*;

    logic [TIMER_WIDTH-1:0] w_last_count;
    logic [TMO_W-1:0]       w_ack_timeout;
    logic                   w_room;
    logic                   w_push;
    logic                   w_in_ready;
    t_item                  w_item;
    t_result                w_result;

    assign w_item.command  = i_item.command;
    assign w_item.tx_byte  = i_item.tx_byte;
    assign w_item.send_ack = i_item.send_ack;
    assign w_item.sda_in   = i_item.sda_in;
    assign i_item.ready    = w_in_ready;

    imbe_cfg_regs #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (i_cfg),
        .o_last_count  (w_last_count),
        .o_ack_timeout (w_ack_timeout)
    );

    imbe_step #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_item.valid),
        .i_item        (w_item),
        .o_in_ready    (w_in_ready),
        .i_last_count  (w_last_count),
        .i_ack_timeout (w_ack_timeout),
        .i_room        (w_room),
        .o_push        (w_push),
        .o_result      (w_result)
    );

    imbe_out_buf u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_result),
        .o_room   (w_room),
        .o_result (o_result)
    );

endmodule

/* rtl/core/imbe_checker.sv */
// port-level checks of the i2c master byte engine, bound to the top level
// depends on imbe_ifs and i2c_master_byte_engine_macros.svh
`include "i2c_master_byte_engine_macros.svh"

module imbe_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    imbe_item_if.sink     i_item,
    imbe_result_if.source o_result
);

    // a finished command leaves the engine idle in the same result
    `IMBE_ASSERT_SAME(a_done_not_busy, i_clk, i_rst_n, o_result.valid && o_result.done_res, !o_result.busy_res, "done_res with busy_res high")

    // requests are only held off while results are backed up
    `IMBE_ASSERT_SAME(a_stall_needs_backlog, i_clk, i_rst_n, !i_item.ready, o_result.valid, "request stalled with no result pending")

    // reset empties the result side
    `IMBE_ASSERT_NEXT(a_reset_clears, i_clk, 1'b1, !i_rst_n, !o_result.valid, "result valid right after reset")

    // a stalled result holds its valid
    `IMBE_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, o_result.valid && !o_result.ready, o_result.valid, "result dropped while stalled")

endmodule

bind i2c_master_byte_engine imbe_checker u_imbe_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_item   (i_item),
    .o_result (o_result)
);

/* sim/i2c_master_byte_engine_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench of the i2c master byte engine: clocked driver and monitor, own bus model
// depends on imbe_pkg, the imbe channel interfaces and the i2c_master_byte_engine rtl
module i2c_master_byte_engine_tb;
    import imbe_pkg::*;

    localparam int                   TMR_W          = 16;
    localparam logic [63:0]          TMR_MAX        = (64'd1 << TMR_W) - 64'd1;
    localparam int                   STALL_LIMIT    = 2000;
    localparam logic [CMD_W-1:0]     CMD_UNUSED_LO  = 3'd5;
    localparam logic [CMD_W-1:0]     CMD_UNUSED_HI  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B    = 2'd3;

    typedef enum logic [4:0] {
        PH_IDLE, PH_START_HI, PH_START_LO, PH_STOP_LO, PH_STOP_HI,
        PH_W_SETUP, PH_W_HIGH, PH_W_LOW, PH_ACK_REL, PH_ACK_HIGH,
        PH_R_LOW, PH_R_HIGH, PH_K_LOW, PH_K_HIGH
    } t_bus_phase;

    typedef enum int {SDA_RANDOM, SDA_HIGH, SDA_LOW} t_sda_pattern;

    logic i_clk;
    logic i_rst_n;

    imbe_item_if   tick_ch ();
    imbe_result_if line_ch ();
    imbe_cfg_if    reg_ch ();

    i2c_master_byte_engine #(
        .TIMER_WIDTH (TMR_W)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (tick_ch),
        .o_result (line_ch),
        .i_cfg    (reg_ch)
    );

    // bus model state
    t_bus_phase        bus_phase;
    logic [3:0]        bit_cnt;
    logic [63:0]       unit_cnt;
    logic [BYTE_W-1:0] shifter;
    logic [TMO_W-1:0]  poll_cnt;
    logic              ack_pick;
    logic              scl_q, sda_q, drv_q;
    logic              err_q;
    logic [BYTE_W-1:0] rx_q;
    logic [UNIT_W-1:0] cfg_unit;
    logic [TMO_W-1:0]  cfg_tmo;

    t_item       pending_ticks[$];
    t_result     expected_lines[$];
    t_item       tick_head;
    t_item       tick_in;
    t_result     line_got;
    t_result     line_want;
    logic        tick_taken;
    int unsigned send_gap_pct;
    int unsigned sink_stall_pct;
    int unsigned ticks_queued;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned commands_done;
    int unsigned ack_timeouts;
    int unsigned reg_writes;

    always #5 i_clk = ~i_clk;

    // one tick of the engine, returns the line levels and flags after it
    function automatic t_result advance_bus(input t_item tk);
        t_result     r;
        logic [63:0] last_tick;
        logic        fin;
        fin = 1'b0;
        last_tick = (cfg_unit == '0) ? 64'd0 : 64'(cfg_unit) - 64'd1;
        if (last_tick > TMR_MAX) last_tick = TMR_MAX;
        if (bus_phase == PH_IDLE) begin
            unit_cnt = '0;
            if (tk.command == CMD_START) begin
                {scl_q, sda_q, drv_q} = 3'b111;
                bit_cnt = 4'd1;
                bus_phase = PH_START_HI;
            end else if (tk.command == CMD_STOP) begin
                {scl_q, sda_q, drv_q} = 3'b001;
                bit_cnt = 4'd1;
                bus_phase = PH_STOP_LO;
            end else if (tk.command == CMD_WRITE) begin
                shifter = tk.tx_byte;
                bit_cnt = '0;
                poll_cnt = '0;
                {scl_q, sda_q, drv_q} = {1'b0, tk.tx_byte[7], 1'b1};
                bus_phase = PH_W_SETUP;
            end else if (tk.command == CMD_READ) begin
                shifter = '0;
                bit_cnt = '0;
                ack_pick = tk.send_ack;
                scl_q = 1'b0;
                drv_q = 1'b0;
                bus_phase = PH_R_LOW;
            end
        end else if (unit_cnt < last_tick) begin
            unit_cnt = (unit_cnt + 64'd1) & TMR_MAX;
        end else begin
            unit_cnt = '0;
            case (bus_phase)
                PH_START_HI: begin
                    if (bit_cnt != 0) begin
                        bit_cnt = bit_cnt - 4'd1;
                    end else begin
                        {scl_q, sda_q, drv_q} = 3'b101;
                        bit_cnt = 4'd1;
                        bus_phase = PH_START_LO;
                    end
                end
                PH_START_LO: begin
                    if (bit_cnt != 0) begin
                        bit_cnt = bit_cnt - 4'd1;
                    end else begin
                        {scl_q, sda_q, drv_q} = 3'b001;
                        bus_phase = PH_IDLE;
                        fin = 1'b1;
                    end
                end
                PH_STOP_LO: begin
                    if (bit_cnt != 0) begin
                        bit_cnt = bit_cnt - 4'd1;
                    end else begin
                        {scl_q, sda_q, drv_q} = 3'b111;
                        bit_cnt = 4'd1;
                        bus_phase = PH_STOP_HI;
                    end
                end
                PH_STOP_HI: begin
                    if (bit_cnt != 0) begin
                        bit_cnt = bit_cnt - 4'd1;
                    end else begin
                        bus_phase = PH_IDLE;
                        fin = 1'b1;
                    end
                end
                PH_W_SETUP: begin
                    scl_q = 1'b1;
                    bus_phase = PH_W_HIGH;
                end
                PH_W_HIGH: begin
                    scl_q = 1'b0;
                    bus_phase = PH_W_LOW;
                end
                PH_W_LOW: begin
                    bit_cnt = bit_cnt + 4'd1;
                    shifter = shifter << 1;
                    if (bit_cnt >= 4'd8) begin
                        {scl_q, sda_q, drv_q} = 3'b010;
                        bus_phase = PH_ACK_REL;
                    end else begin
                        sda_q = shifter[7];
                        bus_phase = PH_W_SETUP;
                    end
                end
                PH_ACK_REL: begin
                    scl_q = 1'b1;
                    bus_phase = PH_ACK_HIGH;
                end
                PH_ACK_HIGH: begin
                    if (!tk.sda_in) begin
                        scl_q = 1'b0;
                        err_q = 1'b0;
                        bus_phase = PH_IDLE;
                        fin = 1'b1;
                    end else if (poll_cnt >= cfg_tmo) begin
                        // give up: flag the error and run a stop
                        err_q = 1'b1;
                        {scl_q, sda_q, drv_q} = 3'b001;
                        bit_cnt = 4'd1;
                        bus_phase = PH_STOP_LO;
                        ack_timeouts++;
                    end else begin
                        poll_cnt = poll_cnt + 1'b1;
                    end
                end
                PH_R_LOW: begin
                    scl_q = 1'b1;
                    shifter = {shifter[6:0], tk.sda_in};
                    bus_phase = PH_R_HIGH;
                end
                PH_R_HIGH: begin
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt >= 4'd8) begin
                        rx_q = shifter;
                        {scl_q, sda_q, drv_q} = {1'b0, !ack_pick, 1'b1};
                        bus_phase = PH_K_LOW;
                    end else begin
                        scl_q = 1'b0;
                        bus_phase = PH_R_LOW;
                    end
                end
                PH_K_LOW: begin
                    scl_q = 1'b1;
                    bus_phase = PH_K_HIGH;
                end
                PH_K_HIGH: begin
                    scl_q = 1'b0;
                    bus_phase = PH_IDLE;
                    fin = 1'b1;
                end
                default: bus_phase = PH_IDLE;
            endcase
        end
        if (fin) commands_done++;
        r.scl_level = scl_q;
        r.sda_level = sda_q;
        r.sda_drive = drv_q;
        r.busy_res  = (bus_phase != PH_IDLE);
        r.done_res  = fin;
        r.rx_byte   = rx_q;
        r.ack_error = err_q;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // command tick followed by enough ticks to let it finish under the current registers, or by a given tail
    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] txb,
                             input logic sack, input t_sda_pattern pattern,
                             input int unsigned noise_pct, input int tail = -1);
        int unsigned units;
        int unsigned ulen;
        int unsigned n;
        t_item       tk;
        case (cmd)
            CMD_START, CMD_STOP: units = 4;
            CMD_WRITE:           units = 30 + cfg_tmo;
            CMD_READ:            units = 18;
            default:             units = 0;
        endcase
        ulen = (cfg_unit == '0) ? 1 : cfg_unit;
        n = (tail >= 0) ? tail : units * ulen + 2 + $urandom_range(0, 3);
        for (int i = 0; i <= n; i++) begin
            if (i == 0) begin
                tk.command  = cmd;
                tk.tx_byte  = txb;
                tk.send_ack = sack;
            end else begin
                tk.command  = ($urandom_range(0, 99) < noise_pct) ?
                              3'($urandom_range(CMD_NONE, CMD_UNUSED_HI)) : CMD_NONE;
                tk.tx_byte  = 8'($urandom_range(0, 255));
                tk.send_ack = 1'($urandom_range(0, 1));
            end
            case (pattern)
                SDA_HIGH: tk.sda_in = 1'b1;
                SDA_LOW:  tk.sda_in = 1'b0;
                default:  tk.sda_in = 1'($urandom_range(0, 1));
            endcase
            pending_ticks.push_back(tk);
        end
        ticks_queued += n + 1;
    endtask

    task automatic wait_drained();
        while (results_seen < ticks_queued) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        reg_ch.valid     <= 1'b1;
        reg_ch.reg_index <= idx;
        reg_ch.wdata     <= data;
        do @(posedge i_clk); while (!reg_ch.ready);
        @(negedge i_clk);
        reg_ch.valid <= 1'b0;
    endtask

    // driver: hold the request until it is taken, pace both sides
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!tick_ch.valid || tick_taken) begin
                if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                    tick_head = pending_ticks.pop_front();
                    tick_ch.valid    <= 1'b1;
                    tick_ch.command  <= tick_head.command;
                    tick_ch.tx_byte  <= tick_head.tx_byte;
                    tick_ch.send_ack <= tick_head.send_ack;
                    tick_ch.sda_in   <= tick_head.sda_in;
                end else begin
                    tick_ch.valid <= 1'b0;
                end
            end
            line_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // monitor: register writes, tick requests into the model, results against it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_taken = 1'b0;
            bus_phase  = PH_IDLE;
            bit_cnt    = '0;
            unit_cnt   = '0;
            shifter    = '0;
            poll_cnt   = '0;
            ack_pick   = 1'b0;
            {scl_q, sda_q, drv_q} = 3'b111;
            err_q      = 1'b0;
            rx_q       = '0;
            cfg_unit   = UNIT_RESET;
            cfg_tmo    = TIMEOUT_RESET;
        end else begin
            tick_taken = tick_ch.valid && tick_ch.ready;
            if (reg_ch.valid && reg_ch.ready) begin
                reg_writes++;
                if (reg_ch.reg_index == REG_UNIT_TICKS) cfg_unit = reg_ch.wdata;
                else if (reg_ch.reg_index == REG_ACK_TIMEOUT) cfg_tmo = reg_ch.wdata[TMO_W-1:0];
            end
            if (tick_taken) begin
                tick_in = '{tick_ch.command, tick_ch.tx_byte, tick_ch.send_ack, tick_ch.sda_in};
                expected_lines.push_back(advance_bus(tick_in));
            end
            if (line_ch.valid && line_ch.ready) begin
                results_seen++;
                line_got = '{line_ch.scl_level, line_ch.sda_level, line_ch.sda_drive,
                             line_ch.busy_res, line_ch.done_res, line_ch.rx_byte,
                             line_ch.ack_error};
                if (expected_lines.size() == 0) begin
                    mismatches++;
                    $display("%0t: result expected nothing, got %0h", $time, line_got);
                end else begin
                    line_want = expected_lines.pop_front();
                    check_field("scl_level", 8'(line_want.scl_level), 8'(line_got.scl_level));
                    check_field("sda_level", 8'(line_want.sda_level), 8'(line_got.sda_level));
                    check_field("sda_drive", 8'(line_want.sda_drive), 8'(line_got.sda_drive));
                    check_field("busy_res", 8'(line_want.busy_res), 8'(line_got.busy_res));
                    check_field("done_res", 8'(line_want.done_res), 8'(line_got.done_res));
                    check_field("rx_byte", line_want.rx_byte, line_got.rx_byte);
                    check_field("ack_error", 8'(line_want.ack_error), 8'(line_got.ack_error));
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (tick_ch.valid && tick_ch.ready) ||
                (line_ch.valid && line_ch.ready) || (reg_ch.valid && reg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        int unsigned        pick;
        int unsigned        mark;
        logic [CMD_W-1:0]   cmd;
        t_sda_pattern       pattern;
        int                 tail;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        tick_ch.valid = 1'b0;
        tick_ch.command = CMD_NONE;
        tick_ch.tx_byte = '0;
        tick_ch.send_ack = 1'b0;
        tick_ch.sda_in = 1'b1;
        line_ch.ready = 1'b0;
        reg_ch.valid = 1'b0;
        reg_ch.reg_index = REG_UNIT_TICKS;
        reg_ch.wdata = '0;
        send_gap_pct = 0;
        sink_stall_pct = 0;
        ticks_queued = 0;
        results_seen = 0;
        mismatches = 0;
        commands_done = 0;
        ack_timeouts = 0;
        reg_writes = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: a start cut off in its first phase, then the unit is changed under it
        queue_cmd(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 0, 60);
        wait_drained();
        write_reg(REG_UNIT_TICKS, 16'hFFFF);
        queue_cmd(CMD_NONE, 8'h00, 1'b0, SDA_HIGH, 0, 20);
        wait_drained();
        // timer already past a zero-length unit: the unit closes on the next tick
        write_reg(REG_UNIT_TICKS, 16'h0000);
        write_reg(REG_ACK_TIMEOUT, 16'h5A10);
        queue_cmd(CMD_NONE, 8'h00, 1'b0, SDA_HIGH, 0, 6);
        queue_cmd(CMD_WRITE, 8'hFF, 1'b0, SDA_LOW, 0);
        queue_cmd(CMD_WRITE, 8'h00, 1'b1, SDA_RANDOM, 0);
        queue_cmd(CMD_WRITE, 8'hA5, 1'b0, SDA_HIGH, 0);
        queue_cmd(CMD_READ, 8'h5A, 1'b1, SDA_RANDOM, 0);
        queue_cmd(CMD_READ, 8'h00, 1'b0, SDA_HIGH, 0);
        queue_cmd(CMD_READ, 8'hFF, 1'b1, SDA_LOW, 0);
        queue_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);
        queue_cmd(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 0);
        for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++)
            queue_cmd(3'(c), 8'hFF, 1'b1, SDA_RANDOM, 0);
        // write lands while the start still runs and must be dropped
        queue_cmd(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 0, 2);
        queue_cmd(CMD_WRITE, 8'h81, 1'b0, SDA_LOW, 0);
        wait_drained();
        write_reg(REG_ACK_TIMEOUT, 16'h0000);
        write_reg(REG_SPARE_A, 16'hFFFF);
        write_reg(REG_SPARE_B, 16'h0001);
        queue_cmd(CMD_WRITE, 8'h3C, 1'b0, SDA_HIGH, 0);
        queue_cmd(CMD_WRITE, 8'hC3, 1'b0, SDA_LOW, 0);
        wait_drained();
        write_reg(REG_UNIT_TICKS, 16'd2);
        queue_cmd(CMD_READ, 8'h00, 1'b1, SDA_RANDOM, 0);
        queue_cmd(CMD_WRITE, 8'($urandom_range(0, 255)), 1'b0, SDA_RANDOM, 0);

        for (int mode = 0; mode < 4; mode++) begin
            wait_drained();
            case (mode)
                0:       begin send_gap_pct = 0;  sink_stall_pct = 0;  end
                1:       begin send_gap_pct = 76; sink_stall_pct = 0;  end
                2:       begin send_gap_pct = 0;  sink_stall_pct = 76; end
                default: begin send_gap_pct = 7;  sink_stall_pct = 7;  end
            endcase
            for (int k = 0; k < 3; k++) begin
                wait_drained();
                case (k)
                    0:       write_reg(REG_UNIT_TICKS, 16'($urandom_range(0, 1)));
                    1:       write_reg(REG_UNIT_TICKS, 16'($urandom_range(2, 4)));
                    default: write_reg(REG_UNIT_TICKS, 16'($urandom_range(1, 3)));
                endcase
                write_reg(REG_ACK_TIMEOUT,
                          {8'($urandom_range(0, 255)), 8'($urandom_range(0, 6))});
                if ($urandom_range(0, 3) == 0)
                    write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                              16'($urandom_range(0, 65535)));
                mark = ticks_queued;
                while (ticks_queued - mark < 20) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 40)      cmd = CMD_WRITE;
                    else if (pick < 70) cmd = CMD_READ;
                    else if (pick < 80) cmd = CMD_START;
                    else if (pick < 90) cmd = CMD_STOP;
                    else                cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
                    pick = $urandom_range(0, 99);
                    pattern = (pick < 60) ? SDA_RANDOM : (pick < 85) ? SDA_HIGH : SDA_LOW;
                    // now and then cut a command short so the next one hits a busy engine
                    tail = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 8)) : -1;
                    queue_cmd(cmd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              pattern, 5, tail);
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (expected_lines.size() != 0) begin
            mismatches++;
            $display("%0t: %0d results never arrived", $time, expected_lines.size());
        end
        $display("%0d bus ticks checked over %0d register writes and four pacing modes",
                 ticks_queued, reg_writes);
        $display("%0d commands completed, %0d writes gave up waiting for ack",
                 commands_done, ack_timeouts);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
